@@ design/bap_pkg.sv @@
`timescale 1ns / 1ps

package bap_pkg;

  localparam int MAX_LINE_WIDTH_DEF = 1024;
  localparam int MAX_BLOCK_SIDE_DEF = 64;

  localparam int PIX_W     = 8;
  localparam int CFG_W     = 13;
  localparam int CFG_IDX_W = 3;

  // Widths of the configuration registers.
  localparam int IMG_W_BITS = 11;
  localparam int IMG_H_BITS = 13;
  localparam int BLK_BITS   = 7;

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_WIDTH  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_HEIGHT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ZERO_BAND_EN = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_BAND_LOW     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_BAND_HIGH    = 3'd6;

  // Values after reset.
  localparam logic [IMG_W_BITS-1:0] RST_IMAGE_WIDTH  = 11'd640;
  localparam logic [IMG_H_BITS-1:0] RST_IMAGE_HEIGHT = 13'd480;
  localparam logic [BLK_BITS-1:0]   RST_BLOCK_WIDTH  = 7'd8;
  localparam logic [BLK_BITS-1:0]   RST_BLOCK_HEIGHT = 7'd8;
  localparam logic [PIX_W-1:0]      RST_BAND_LOW     = 8'd0;
  localparam logic [PIX_W-1:0]      RST_BAND_HIGH    = 8'd255;

  localparam logic [PIX_W-1:0] PIX_MAX = 8'hFF;

  typedef struct packed {
    logic accept;
    logic update;
    logic div_start;
    logic out_load;
  } bap_cmd_t;

  typedef struct packed {
    logic emit;
    logic div_busy;
    logic div_done;
    logic out_free;
  } bap_sts_t;

endpackage

@@ design/bap_ctrl.sv @@
`timescale 1ns / 1ps

module bap_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  bap_pkg::bap_sts_t sts,
  output bap_pkg::bap_cmd_t cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_UPD  = 2'd1;
  localparam logic [1:0] S_DIV  = 2'd2;
  localparam logic [1:0] S_LOAD = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next    = state;
    cmd.accept    = 1'b0;
    cmd.update    = 1'b0;
    cmd.div_start = 1'b0;
    cmd.out_load  = 1'b0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = S_UPD;
        end
      end
      S_UPD: begin
        cmd.update = 1'b1;
        if (sts.emit) begin
          cmd.div_start = 1'b1;
          state_next    = S_DIV;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_DIV: begin
        if (sts.div_done) begin
          state_next = S_LOAD;
        end
      end
      S_LOAD: begin
        // Wait here until the output register is empty or being emptied.
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

@@ design/bap_div.sv @@
`timescale 1ns / 1ps

module bap_div #(
  parameter int NUM_W = 20,
  parameter int DEN_W = 13
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] dividend,
  input  logic [DEN_W-1:0] divisor,
  output logic             busy,
  output logic             done,
  output logic [NUM_W-1:0] quotient
);

  localparam int CNT_W = (NUM_W > 1) ? $clog2(NUM_W) : 1;

  logic [CNT_W-1:0] cnt;
  logic [DEN_W-1:0] rem;
  logic [DEN_W-1:0] dvs;
  logic [NUM_W-1:0] quo;
  logic [DEN_W:0]   rem_sh;
  logic             fits;

  // One quotient bit per cycle, most significant first.
  assign rem_sh   = {rem, quo[NUM_W-1]};
  assign fits     = (rem_sh >= {1'b0, dvs});
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && (cnt == CNT_W'(NUM_W - 1))) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      cnt <= '0;
      rem <= '0;
      quo <= dividend;
      dvs <= divisor;
    end else if (busy) begin
      cnt <= cnt + CNT_W'(1);
      if (fits) begin
        rem <= DEN_W'(rem_sh - {1'b0, dvs});
      end else begin
        rem <= rem_sh[DEN_W-1:0];
      end
      quo <= {quo[NUM_W-2:0], fits};
    end
  end

endmodule

@@ design/bap_dp.sv @@
`timescale 1ns / 1ps

module bap_dp #(
  parameter  int MAX_LINE_WIDTH = bap_pkg::MAX_LINE_WIDTH_DEF,
  parameter  int MAX_BLOCK_SIDE = bap_pkg::MAX_BLOCK_SIDE_DEF,
  localparam int COL_W          = $clog2(MAX_LINE_WIDTH),
  localparam int LINE_W         = $clog2(MAX_LINE_WIDTH * 4)
) (
  input  logic                          clk,
  input  logic                          rst,
  input  bap_pkg::bap_cmd_t             cmd,
  output bap_pkg::bap_sts_t             sts,
  input  logic                          cfg_we,
  input  logic [bap_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bap_pkg::CFG_W-1:0]     cfg_data,
  input  logic [bap_pkg::PIX_W-1:0]     pixel,
  input  logic                          frame_start,
  input  logic                          out_ready,
  output logic                          out_valid,
  output logic [bap_pkg::PIX_W-1:0]     block_value,
  output logic [COL_W-1:0]              block_col,
  output logic [LINE_W-1:0]             block_row,
  output logic                          frame_last
);

  localparam int W_W    = $clog2(MAX_LINE_WIDTH + 1);
  localparam int H_W    = $clog2(MAX_LINE_WIDTH * 4 + 1);
  localparam int B_W    = $clog2(MAX_BLOCK_SIDE + 1);
  localparam int CIB_W  = (MAX_BLOCK_SIDE > 2) ? $clog2(MAX_BLOCK_SIDE) : 1;
  localparam int AREA_W = $clog2(MAX_BLOCK_SIDE * MAX_BLOCK_SIDE + 1);
  localparam int SUM_W  = bap_pkg::PIX_W + 2 * $clog2(MAX_BLOCK_SIDE);
  localparam int PC_W   = W_W + B_W + 1;
  localparam int PR_W   = H_W + B_W + 1;

  // Configuration registers.
  logic [bap_pkg::IMG_W_BITS-1:0] image_width;
  logic [bap_pkg::IMG_H_BITS-1:0] image_height;
  logic [bap_pkg::BLK_BITS-1:0]   block_width;
  logic [bap_pkg::BLK_BITS-1:0]   block_height;
  logic                           zero_band_enable;
  logic [bap_pkg::PIX_W-1:0]      band_low;
  logic [bap_pkg::PIX_W-1:0]      band_high;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width      <= bap_pkg::RST_IMAGE_WIDTH;
      image_height     <= bap_pkg::RST_IMAGE_HEIGHT;
      block_width      <= bap_pkg::RST_BLOCK_WIDTH;
      block_height     <= bap_pkg::RST_BLOCK_HEIGHT;
      zero_band_enable <= 1'b0;
      band_low         <= bap_pkg::RST_BAND_LOW;
      band_high        <= bap_pkg::RST_BAND_HIGH;
    end else if (cfg_we) begin
      case (cfg_index)
        bap_pkg::REG_IMAGE_WIDTH:  image_width      <= cfg_data[bap_pkg::IMG_W_BITS-1:0];
        bap_pkg::REG_IMAGE_HEIGHT: image_height     <= cfg_data[bap_pkg::IMG_H_BITS-1:0];
        bap_pkg::REG_BLOCK_WIDTH:  block_width      <= cfg_data[bap_pkg::BLK_BITS-1:0];
        bap_pkg::REG_BLOCK_HEIGHT: block_height     <= cfg_data[bap_pkg::BLK_BITS-1:0];
        bap_pkg::REG_ZERO_BAND_EN: zero_band_enable <= cfg_data[0];
        bap_pkg::REG_BAND_LOW:     band_low         <= cfg_data[bap_pkg::PIX_W-1:0];
        bap_pkg::REG_BAND_HIGH:    band_high        <= cfg_data[bap_pkg::PIX_W-1:0];
        default: ;
      endcase
    end
  end

  // Effective sizes; zero acts as one and large values saturate.
  logic [W_W-1:0] w;
  logic [H_W-1:0] h;
  logic [B_W-1:0] bw;
  logic [B_W-1:0] bh;

  assign w  = (image_width == '0) ? W_W'(1) :
              (image_width > MAX_LINE_WIDTH) ? W_W'(MAX_LINE_WIDTH) : W_W'(image_width);
  assign h  = (image_height == '0) ? H_W'(1) :
              (image_height > MAX_LINE_WIDTH * 4) ? H_W'(MAX_LINE_WIDTH * 4) :
              H_W'(image_height);
  assign bw = (block_width == '0) ? B_W'(1) :
              (block_width > MAX_BLOCK_SIDE) ? B_W'(MAX_BLOCK_SIDE) : B_W'(block_width);
  assign bh = (block_height == '0) ? B_W'(1) :
              (block_height > MAX_BLOCK_SIDE) ? B_W'(MAX_BLOCK_SIDE) : B_W'(block_height);

  // Raster position.
  logic [COL_W-1:0]  pc, pc_next, cur_pc;
  logic [LINE_W-1:0] pl, pl_next, cur_pl;
  logic [CIB_W-1:0]  cib, cib_next, cur_cib;
  logic [CIB_W-1:0]  lib, lib_next, cur_lib;
  logic [COL_W-1:0]  bci, bci_next, cur_bci;
  logic [LINE_W-1:0] bri, bri_next, cur_bri;

  // A frame start restarts the position before the pixel is placed.
  assign cur_pc  = frame_start ? '0 : pc;
  assign cur_pl  = frame_start ? '0 : pl;
  assign cur_cib = frame_start ? '0 : cib;
  assign cur_lib = frame_start ? '0 : lib;
  assign cur_bci = frame_start ? '0 : bci;
  assign cur_bri = frame_start ? '0 : bri;

  always_comb begin
    pc_next  = cur_pc;
    pl_next  = cur_pl;
    cib_next = cur_cib;
    lib_next = cur_lib;
    bci_next = cur_bci;
    bri_next = cur_bri;
    if ((W_W'(cur_pc) + W_W'(1)) >= w) begin
      pc_next  = '0;
      cib_next = '0;
      bci_next = '0;
      if ((H_W'(cur_pl) + H_W'(1)) >= h) begin
        pl_next  = '0;
        lib_next = '0;
        bri_next = '0;
      end else begin
        pl_next = cur_pl + LINE_W'(1);
        if ((B_W'(cur_lib) + B_W'(1)) >= bh) begin
          lib_next = '0;
          bri_next = cur_bri + LINE_W'(1);
        end else begin
          lib_next = cur_lib + CIB_W'(1);
        end
      end
    end else begin
      pc_next = cur_pc + COL_W'(1);
      if ((B_W'(cur_cib) + B_W'(1)) >= bw) begin
        cib_next = '0;
        bci_next = cur_bci + COL_W'(1);
      end else begin
        cib_next = cur_cib + CIB_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc  <= '0;
      pl  <= '0;
      cib <= '0;
      lib <= '0;
      bci <= '0;
      bri <= '0;
    end else if (cmd.accept) begin
      pc  <= pc_next;
      pl  <= pl_next;
      cib <= cib_next;
      lib <= lib_next;
      bci <= bci_next;
      bri <= bri_next;
    end
  end

  // Per-item stage captured at the input transfer.
  logic [bap_pkg::PIX_W-1:0] pix_q;
  logic [COL_W-1:0]          idx_q;
  logic [LINE_W-1:0]         row_q;
  logic                      first_q;
  logic                      end_q;
  logic [PC_W-1:0]           prod_c_q;
  logic [PR_W-1:0]           prod_r_q;
  logic [AREA_W-1:0]         area_q;

  // The block lies inside the image when (index + 1) * size fits the image.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      pix_q    <= pixel;
      idx_q    <= cur_bci;
      row_q    <= cur_bri;
      first_q  <= (cur_lib == '0) && (cur_cib == '0);
      end_q    <= ((B_W'(cur_lib) + B_W'(1)) >= bh) && ((B_W'(cur_cib) + B_W'(1)) >= bw);
      prod_c_q <= PC_W'(W_W'(cur_bci) + W_W'(1)) * PC_W'(bw);
      prod_r_q <= PR_W'(H_W'(cur_bri) + H_W'(1)) * PR_W'(bh);
      area_q   <= AREA_W'(bw) * AREA_W'(bh);
    end
  end

  // Column accumulators.
  logic [SUM_W-1:0] col_sums [MAX_LINE_WIDTH];
  logic [SUM_W-1:0] rd_data;
  logic [SUM_W-1:0] new_sum;
  logic             in_rng;
  logic             is_last;
  logic             mem_we;

  assign in_rng  = (prod_c_q <= PC_W'(w)) && (prod_r_q <= PR_W'(h));
  assign is_last = ((prod_c_q + PC_W'(bw)) > PC_W'(w)) &&
                   ((prod_r_q + PR_W'(bh)) > PR_W'(h));
  assign new_sum = first_q ? SUM_W'(pix_q) : (rd_data + SUM_W'(pix_q));
  assign mem_we  = cmd.update && in_rng;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      col_sums[idx_q] <= new_sum;
    end
    if (cmd.accept) begin
      rd_data <= col_sums[cur_bci];
    end
  end

  logic [COL_W-1:0]  res_col;
  logic [LINE_W-1:0] res_row;
  logic              res_last;

  always_ff @(posedge clk) begin
    if (cmd.update) begin
      res_col  <= idx_q;
      res_row  <= row_q;
      res_last <= is_last;
    end
  end

  logic             div_busy;
  logic             div_done;
  logic [SUM_W-1:0] quo;

  bap_div #(
    .NUM_W (SUM_W),
    .DEN_W (AREA_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (new_sum),
    .divisor  (area_q),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (quo)
  );

  logic [bap_pkg::PIX_W-1:0] mean;
  logic [bap_pkg::PIX_W-1:0] mean_out;

  assign mean     = (quo > SUM_W'(bap_pkg::PIX_MAX)) ? bap_pkg::PIX_MAX :
                    quo[bap_pkg::PIX_W-1:0];
  assign mean_out = (zero_band_enable && (mean > band_low) && (mean < band_high)) ?
                    '0 : mean;

  // Output register; it frees up in the same cycle as its transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      block_value <= mean_out;
      block_col   <= res_col;
      block_row   <= res_row;
      frame_last  <= res_last;
    end
  end

  assign sts.emit     = in_rng && end_q;
  assign sts.div_busy = div_busy;
  assign sts.div_done = div_done;
  assign sts.out_free = !out_valid || out_ready;

endmodule

@@ design/block_average_pixelate.sv @@
`timescale 1ns / 1ps
// Block-mean downsampler for an 8-bit grayscale pixel stream in raster order.
// Input channel: pixel and frame_start move on in_valid/in_ready. A frame_start
// of one places that pixel at the top-left corner of a new image.
// Output channel: block_value, block_col, block_row and frame_last move on
// out_valid/out_ready, one transfer for each complete block, in raster order of
// the blocks' bottom-right pixels.
// Configuration: cfg_we writes cfg_data into the register chosen by cfg_index
// (0 image_width, 1 image_height, 2 block_width, 3 block_height,
// 4 zero_band_enable, 5 band_low, 6 band_high). Write only while idle.
// Pixel flow: a pixel that does not close a block passes the transfer and then a
// read-modify-write of the column accumulator memory. A pixel that closes a
// block also runs the sequential divider, one quotient bit per cycle, and waits
// for a free output register; no new pixel is taken until its result is
// presented, and the next pixel can be taken in that same cycle.
// Reset clears the raster position and loads the default register values; the
// accumulator memory needs no clearing since each block starts by overwriting.
// A stalled receiver holds the result in the output register; the block keeps
// taking pixels until another finished result needs that register.
module block_average_pixelate #(
  parameter  int MAX_LINE_WIDTH = bap_pkg::MAX_LINE_WIDTH_DEF,
  parameter  int MAX_BLOCK_SIDE = bap_pkg::MAX_BLOCK_SIDE_DEF,
  localparam int COL_W          = $clog2(MAX_LINE_WIDTH),
  localparam int LINE_W         = $clog2(MAX_LINE_WIDTH * 4)
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [bap_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bap_pkg::CFG_W-1:0]     cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [bap_pkg::PIX_W-1:0]     pixel,
  input  logic                          frame_start,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [bap_pkg::PIX_W-1:0]     block_value,
  output logic [COL_W-1:0]              block_col,
  output logic [LINE_W-1:0]             block_row,
  output logic                          frame_last
);

  bap_pkg::bap_cmd_t cmd;
  bap_pkg::bap_sts_t sts;

  bap_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  bap_dp #(
    .MAX_LINE_WIDTH (MAX_LINE_WIDTH),
    .MAX_BLOCK_SIDE (MAX_BLOCK_SIDE)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sts         (sts),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .pixel       (pixel),
    .frame_start (frame_start),
    .out_ready   (out_ready),
    .out_valid   (out_valid),
    .block_value (block_value),
    .block_col   (block_col),
    .block_row   (block_row),
    .frame_last  (frame_last)
  );

`ifndef ASSERT_OFF
  // The accumulator update always directly follows a pixel transfer.
  assert property (@(posedge clk) disable iff (rst) cmd.update |-> $past(cmd.accept))
    else $error("accumulator update without a preceding pixel transfer");

  // A new pixel is never taken while the divider still works on a block.
  assert property (@(posedge clk) disable iff (rst) cmd.accept |-> !sts.div_busy)
    else $error("pixel transfer while the divider is busy");

  // A result is loaded only when the output register can take it.
  assert property (@(posedge clk) disable iff (rst) cmd.out_load |-> sts.out_free)
    else $error("output register overwritten before its transfer");

  // No pixel is taken in the cycle a finished quotient becomes ready.
  assert property (@(posedge clk) disable iff (rst) sts.div_done |-> !cmd.accept)
    else $error("pixel transfer while a quotient waits to be loaded");
`endif

endmodule
